// ===== rtl/dad_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date adder package
// Shared widths, calendar constants, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package dad_pkg;

    // Width of the day count and of the shared subtract unit.
    localparam int COUNT_BITS = 16;
    localparam int SUB_W      = COUNT_BITS + 1;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int AMT_W   = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd16383;
    localparam logic [AMT_W-1:0]   DAYS_COMMON = 9'd365;
    localparam logic [AMT_W-1:0]   DAYS_LEAP   = 9'd366;
    localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
    localparam logic [6:0]         CENT_LAST  = 7'd99;

    // Division of a year by 100 through a reciprocal: exact for 14-bit years.
    localparam int DIV100_MUL   = 5243;
    localparam int DIV100_SHIFT = 19;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_REM,
        S_CHECK,
        S_YEAR,
        S_MONTH,
        S_DONE
    } t_state;

    // Result of the shared compare and subtract unit.
    typedef struct packed {
        logic             ge;
        logic [SUB_W-1:0] diff;
    } t_sub_res;

    // Leap flags of the current year and of the year after it.
    typedef struct packed {
        logic cur;
        logic nxt;
    } t_leap;

    // Quotient of a year by 100.
    function automatic logic [7:0] year_div100(input logic [YEAR_W-1:0] y);
        logic [26:0] prod;
        prod = 27'(y) * 27'(DIV100_MUL);
        return 8'(prod >> DIV100_SHIFT);
    endfunction

    // Number of days in a month; codes outside 1..12 read as 31.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== rtl/dad_sub_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared compare and subtract unit
// Subtracts a step amount from the remaining day count and flags whether the
// count covers the whole step.
// ----------------------------------------------------------------------------
module dad_sub_unit (
    input  logic [dad_pkg::SUB_W-1:0] i_a,
    input  logic [dad_pkg::SUB_W-1:0] i_b,
    output dad_pkg::t_sub_res         o_res
);

    logic [dad_pkg::SUB_W:0] w_full;

    // One wide subtract; the borrow decides the compare.
    assign w_full     = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_full[dad_pkg::SUB_W];
    assign o_res.diff = w_full[dad_pkg::SUB_W-1:0];

endmodule

// ===== rtl/dad_leap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Leap year tracker logic
// Derives the leap flags of the current and the following year from the year
// and its running remainder and quotient by 100.
// ----------------------------------------------------------------------------
module dad_leap (
    input  logic [dad_pkg::YEAR_W-1:0] i_year,
    input  logic [6:0]                 i_rem100,
    input  logic [7:0]                 i_quo100,
    output dad_pkg::t_leap             o_leap
);

    logic [6:0] w_rem_nxt;
    logic [1:0] w_quo_nxt;

    // Counters of the following year.
    always_comb begin
        if (i_rem100 == dad_pkg::CENT_LAST) begin
            w_rem_nxt = '0;
            w_quo_nxt = i_quo100[1:0] + 2'd1;
        end else begin
            w_rem_nxt = i_rem100 + 7'd1;
            w_quo_nxt = i_quo100[1:0];
        end
    end

    // Divisible by 4, and either not a century or a century divisible by 400.
    assign o_leap.cur = (i_year[1:0] == 2'd0) &&
                        ((i_rem100 != 7'd0) || (i_quo100[1:0] == 2'd0));
    assign o_leap.nxt = (i_year[1:0] == 2'd3) &&
                        ((w_rem_nxt != 7'd0) || (w_quo_nxt == 2'd0));

endmodule

// ===== rtl/date_add_days.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date adder
// Adds a day count to a date and returns the resulting date.
// ----------------------------------------------------------------------------
// Usage: drive i_day_count, i_day, i_month and i_year and raise start while
// busy is low; the item is taken at that clock edge and busy stays high until
// the result has been shown. The result appears on the o_ fields for exactly
// one cycle with o_done high; the receiver cannot hold it off.
// Steps: S_SPLIT and S_REM divide the year by 100; S_CHECK checks the date
// and, if the count reaches past the month end, steps to the first of the
// next month; S_YEAR skips whole years; S_MONTH steps whole months (at most
// 11) and places the remaining days; S_DONE shows the result. Each check,
// year or month step is one pass through the single shared compare and
// subtract unit. An invalid date goes from S_CHECK to S_DONE. A new item is
// taken the cycle after o_done. An invalid date raises o_bad_date, and a
// year beyond 16383 raises o_year_overflow; both echo the input date.
// Reset is synchronous and active low; it returns the block to idle and
// drops any item in progress.
// ----------------------------------------------------------------------------
module date_add_days (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [dad_pkg::COUNT_BITS-1:0] i_day_count,
    input  logic [dad_pkg::DAY_W-1:0]      i_day,
    input  logic [dad_pkg::MONTH_W-1:0]    i_month,
    input  logic [dad_pkg::YEAR_W-1:0]     i_year,
    output logic                           o_done,
    output logic [dad_pkg::DAY_W-1:0]      o_new_day,
    output logic [dad_pkg::MONTH_W-1:0]    o_new_month,
    output logic [dad_pkg::YEAR_W-1:0]     o_new_year,
    output logic                           o_bad_date,
    output logic                           o_year_overflow
);

    dad_pkg::t_state r_state, n_state;
    logic [dad_pkg::COUNT_BITS-1:0] r_cnt, n_cnt;
    logic [dad_pkg::DAY_W-1:0]      r_d, n_d, r_d0;
    logic [dad_pkg::MONTH_W-1:0]    r_m, n_m, r_m0;
    logic [dad_pkg::YEAR_W-1:0]     r_y, n_y, r_y0;
    logic [6:0]                     r_rem, n_rem;
    logic [7:0]                     r_quo, n_quo;
    logic                           r_bad, n_bad, r_ovf, n_ovf;

    logic [dad_pkg::AMT_W-1:0] w_amt;
    logic [dad_pkg::DAY_W-1:0] w_len;
    logic [5:0]                w_to_next;
    logic [dad_pkg::YEAR_W-1:0] w_q100;
    dad_pkg::t_sub_res         w_sub;
    dad_pkg::t_leap            w_leap;

    // Shared step unit and leap tracker.
    dad_sub_unit u_sub (
        .i_a   (dad_pkg::SUB_W'(r_cnt)),
        .i_b   (dad_pkg::SUB_W'(w_amt)),
        .o_res (w_sub)
    );

    dad_leap u_leap (
        .i_year   (r_y),
        .i_rem100 (r_rem),
        .i_quo100 (r_quo),
        .o_leap   (w_leap)
    );

    // Month length of the current month and days left to its end, inclusive.
    assign w_len     = dad_pkg::month_len(r_m, w_leap.cur);
    assign w_to_next = 6'(w_len) - 6'(r_d) + 6'd1;
    assign w_q100    = dad_pkg::YEAR_W'({r_quo, 6'd0}) + dad_pkg::YEAR_W'({r_quo, 5'd0})
                     + dad_pkg::YEAR_W'({r_quo, 2'd0});

    // Step amount fed to the shared unit in each state.
    always_comb begin
        unique case (r_state)
            dad_pkg::S_CHECK: w_amt = dad_pkg::AMT_W'(w_to_next);
            dad_pkg::S_YEAR: begin
                // The span holds a 29 February when it starts by February of a
                // leap year, or starts later and the following year is leap.
                if ((r_m <= dad_pkg::MONTH_FEB) ? w_leap.cur : w_leap.nxt) begin
                    w_amt = dad_pkg::DAYS_LEAP;
                end else begin
                    w_amt = dad_pkg::DAYS_COMMON;
                end
            end
            dad_pkg::S_MONTH: w_amt = dad_pkg::AMT_W'(w_len);
            default:          w_amt = '0;
        endcase
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_d     = r_d;
        n_m     = r_m;
        n_y     = r_y;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_bad   = r_bad;
        n_ovf   = r_ovf;
        unique case (r_state)
            dad_pkg::S_IDLE: begin
                if (start) begin
                    n_state = dad_pkg::S_SPLIT;
                    n_cnt   = i_day_count;
                    n_d     = i_day;
                    n_m     = i_month;
                    n_y     = i_year;
                    n_bad   = 1'b0;
                    n_ovf   = 1'b0;
                end
            end
            dad_pkg::S_SPLIT: begin
                n_quo   = dad_pkg::year_div100(r_y);
                n_state = dad_pkg::S_REM;
            end
            dad_pkg::S_REM: begin
                n_rem   = 7'(r_y - w_q100);
                n_state = dad_pkg::S_CHECK;
            end
            dad_pkg::S_CHECK: begin
                if ((r_m == '0) || (r_m > dad_pkg::MONTH_DEC) || (r_d == '0) ||
                    (r_d > w_len)) begin
                    n_bad   = 1'b1;
                    n_state = dad_pkg::S_DONE;
                end else if (w_sub.ge) begin
                    // Move to the first day of the following month.
                    n_cnt   = dad_pkg::COUNT_BITS'(w_sub.diff);
                    n_d     = dad_pkg::DAY_W'(1);
                    n_state = dad_pkg::S_YEAR;
                    if (r_m == dad_pkg::MONTH_DEC) begin
                        n_m = dad_pkg::MONTH_JAN;
                        if (r_y == dad_pkg::YEAR_MAX) begin
                            n_ovf   = 1'b1;
                            n_state = dad_pkg::S_DONE;
                        end else begin
                            n_y = r_y + 1'b1;
                            if (r_rem == dad_pkg::CENT_LAST) begin
                                n_rem = '0;
                                n_quo = r_quo + 8'd1;
                            end else begin
                                n_rem = r_rem + 7'd1;
                            end
                        end
                    end else begin
                        n_m = r_m + 1'b1;
                    end
                end else begin
                    n_d     = r_d + dad_pkg::DAY_W'(r_cnt);
                    n_state = dad_pkg::S_DONE;
                end
            end
            dad_pkg::S_YEAR: begin
                // Skip a whole year from the first of the month.
                if (w_sub.ge) begin
                    n_cnt = dad_pkg::COUNT_BITS'(w_sub.diff);
                    if (r_y == dad_pkg::YEAR_MAX) begin
                        n_ovf   = 1'b1;
                        n_state = dad_pkg::S_DONE;
                    end else begin
                        n_y = r_y + 1'b1;
                        if (r_rem == dad_pkg::CENT_LAST) begin
                            n_rem = '0;
                            n_quo = r_quo + 8'd1;
                        end else begin
                            n_rem = r_rem + 7'd1;
                        end
                    end
                end else begin
                    n_state = dad_pkg::S_MONTH;
                end
            end
            dad_pkg::S_MONTH: begin
                // Step whole months, then place the remaining days.
                if (w_sub.ge) begin
                    n_cnt = dad_pkg::COUNT_BITS'(w_sub.diff);
                    if (r_m == dad_pkg::MONTH_DEC) begin
                        n_m = dad_pkg::MONTH_JAN;
                        if (r_y == dad_pkg::YEAR_MAX) begin
                            n_ovf   = 1'b1;
                            n_state = dad_pkg::S_DONE;
                        end else begin
                            n_y = r_y + 1'b1;
                            if (r_rem == dad_pkg::CENT_LAST) begin
                                n_rem = '0;
                                n_quo = r_quo + 8'd1;
                            end else begin
                                n_rem = r_rem + 7'd1;
                            end
                        end
                    end else begin
                        n_m = r_m + 1'b1;
                    end
                end else begin
                    n_d     = dad_pkg::DAY_W'(1) + dad_pkg::DAY_W'(r_cnt);
                    n_state = dad_pkg::S_DONE;
                end
            end
            dad_pkg::S_DONE: begin
                n_state = dad_pkg::S_IDLE;
            end
            default: begin
                n_state = dad_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dad_pkg::S_IDLE;
            r_bad   <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bad   <= n_bad;
            r_ovf   <= n_ovf;
        end
    end

    // Datapath registers and the captured input date.
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_d   <= n_d;
        r_m   <= n_m;
        r_y   <= n_y;
        r_rem <= n_rem;
        r_quo <= n_quo;
        if (r_state == dad_pkg::S_IDLE && start) begin
            r_d0 <= i_day;
            r_m0 <= i_month;
            r_y0 <= i_year;
        end
    end

    // Result ports; flagged items echo the input date.
    assign busy            = (r_state != dad_pkg::S_IDLE);
    assign o_done          = (r_state == dad_pkg::S_DONE);
    assign o_bad_date      = r_bad;
    assign o_year_overflow = r_ovf;
    assign o_new_day       = (r_bad || r_ovf) ? r_d0 : r_d;
    assign o_new_month     = (r_bad || r_ovf) ? r_m0 : r_m;
    assign o_new_year      = (r_bad || r_ovf) ? r_y0 : r_y;

`ifndef ASSERT_OFF
    // An accepted item keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    // Results are single-cycle and never back to back.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // The two flags exclude each other.
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_bad_date && o_year_overflow))
        else $error("bad date and overflow raised together");

    // A computed result has a month in range.
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_bad_date) |-> (o_new_month >= 4'd1 && o_new_month <= 4'd12))
        else $error("result month out of range");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date adder testbench
// Drives dates and day counts into the date adder and compares every result
// with its table entry if known, else a calendar predictor built on serial day
// numbers. Directed table items come first, then random items, all with random gaps.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_RANDOM       = 1850;
    localparam int MAX_GAP        = 12;
    localparam int TAIL_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam longint unsigned ERA_DAYS = 146097;

    // One result item as the block shows it.
    typedef struct packed {
        logic [dad_pkg::DAY_W-1:0]   day;
        logic [dad_pkg::MONTH_W-1:0] month;
        logic [dad_pkg::YEAR_W-1:0]  year;
        logic                        bad;
        logic                        ovf;
    } t_date_res;

    // One row of the directed table; res is only used when known is set.
    typedef struct {
        logic [dad_pkg::COUNT_BITS-1:0] count;
        logic [dad_pkg::DAY_W-1:0]      day;
        logic [dad_pkg::MONTH_W-1:0]    month;
        logic [dad_pkg::YEAR_W-1:0]     year;
        bit                             known;
        t_date_res                      res;
    } t_stim_row;

    localparam t_date_res NO_RES = '0;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [dad_pkg::COUNT_BITS-1:0] i_day_count;
    logic [dad_pkg::DAY_W-1:0]      i_day;
    logic [dad_pkg::MONTH_W-1:0]    i_month;
    logic [dad_pkg::YEAR_W-1:0]     i_year;
    logic                           o_done;
    logic [dad_pkg::DAY_W-1:0]      o_new_day;
    logic [dad_pkg::MONTH_W-1:0]    o_new_month;
    logic [dad_pkg::YEAR_W-1:0]     o_new_year;
    logic                           o_bad_date;
    logic                           o_year_overflow;

    t_date_res   expected_dates [$];
    t_stim_row   dir_rows [$];
    bit          pend_known;
    t_date_res   pend_res;
    int unsigned mismatch_cnt;
    int unsigned idle_cycles;

    date_add_days i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_day_count     (i_day_count),
        .i_day           (i_day),
        .i_month         (i_month),
        .i_year          (i_year),
        .o_done          (o_done),
        .o_new_day       (o_new_day),
        .o_new_month     (o_new_month),
        .o_new_year      (o_new_year),
        .o_bad_date      (o_bad_date),
        .o_year_overflow (o_year_overflow)
    );

    // Clock with a 10 ns period.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gregorian leap rule; year 0 counts as a leap year.
    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        if (m == dad_pkg::MONTH_FEB) begin
            return leap_year(y) ? 29 : 28;
        end
        // April, June, September and November are the short months.
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    // Day number counted from a March-based year, shifted by one 400-year era.
    function automatic longint unsigned day_serial(input int unsigned d, input int unsigned m,
                                                   input int unsigned y);
        longint unsigned yy, era, yoe, mp, doy;
        yy  = longint'(y) + 400 - ((m <= 2) ? 1 : 0);
        era = yy / 400;
        yoe = yy - era * 400;
        mp  = (longint'(m) + 9) % 12;
        doy = (153 * mp + 2) / 5 + d - 1;
        return era * ERA_DAYS + yoe * 365 + yoe / 4 - yoe / 100 + doy;
    endfunction

    // Expected result of one item.
    function automatic t_date_res predict_date(input logic [dad_pkg::COUNT_BITS-1:0] cnt,
                                               input logic [dad_pkg::DAY_W-1:0] d,
                                               input logic [dad_pkg::MONTH_W-1:0] m,
                                               input logic [dad_pkg::YEAR_W-1:0] y);
        t_date_res       r;
        longint unsigned z, era, doe, yoe, doy, mp, nd, nm, ny;
        r = '{day: d, month: m, year: y, bad: 1'b0, ovf: 1'b0};
        if (m < dad_pkg::MONTH_JAN || m > dad_pkg::MONTH_DEC || d == 0 ||
            d > month_days(m, y)) begin
            r.bad = 1'b1;
        end else begin
            z   = day_serial(d, m, y) + longint'(cnt);
            era = z / ERA_DAYS;
            doe = z - era * ERA_DAYS;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            nd  = doy - (153 * mp + 2) / 5 + 1;
            nm  = (mp < 10) ? mp + 3 : mp - 9;
            ny  = yoe + era * 400 + ((nm <= 2) ? 1 : 0) - 400;
            if (ny > longint'(dad_pkg::YEAR_MAX)) begin
                r.ovf = 1'b1;
            end else begin
                r.day   = dad_pkg::DAY_W'(nd);
                r.month = dad_pkg::MONTH_W'(nm);
                r.year  = dad_pkg::YEAR_W'(ny);
            end
        end
        return r;
    endfunction

    function automatic t_date_res res_of(input int unsigned d, input int unsigned m,
                                         input int unsigned y, input bit bad, input bit ovf);
        return '{day: dad_pkg::DAY_W'(d), month: dad_pkg::MONTH_W'(m),
                 year: dad_pkg::YEAR_W'(y), bad: bad, ovf: ovf};
    endfunction

    task automatic add_row(input int unsigned cnt, input int unsigned d, input int unsigned m,
                           input int unsigned y, input bit known, input t_date_res r);
        t_stim_row row;
        row.count = dad_pkg::COUNT_BITS'(cnt);
        row.day   = dad_pkg::DAY_W'(d);
        row.month = dad_pkg::MONTH_W'(m);
        row.year  = dad_pkg::YEAR_W'(y);
        row.known = known;
        row.res   = r;
        dir_rows.push_back(row);
    endtask

    // Offer one item after a random gap and hold it until the block takes it.
    task automatic send_item(input logic [dad_pkg::COUNT_BITS-1:0] cnt,
                             input logic [dad_pkg::DAY_W-1:0] d,
                             input logic [dad_pkg::MONTH_W-1:0] m,
                             input logic [dad_pkg::YEAR_W-1:0] y,
                             input bit known, input t_date_res r);
        int unsigned gap;
        gap = $urandom_range(0, MAX_GAP);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start       <= 1'b1;
        i_day_count <= cnt;
        i_day       <= d;
        i_month     <= m;
        i_year      <= y;
        pend_known  = known;
        pend_res    = r;
        do @(posedge i_clk); while (busy);
    endtask

    // Result checking, expectation capture and the watchdog.
    always @(posedge i_clk) begin
        t_date_res got;
        t_date_res want;
        if (i_rst_n) begin
            if (o_done) begin
                got = '{day: o_new_day, month: o_new_month, year: o_new_year,
                        bad: o_bad_date, ovf: o_year_overflow};
                if (expected_dates.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS) begin
                        $display("unexpected result: %0d/%0d/%0d bad=%0d ovf=%0d",
                                 got.day, got.month, got.year, got.bad, got.ovf);
                    end
                end else begin
                    want = expected_dates.pop_front();
                    if (got.day !== want.day || got.month !== want.month ||
                        got.year !== want.year || got.bad !== want.bad ||
                        got.ovf !== want.ovf) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS) begin
                            $display(
                                "exp %0d/%0d/%0d bad=%0d ovf=%0d, got %0d/%0d/%0d bad=%0d ovf=%0d",
                                want.day, want.month, want.year, want.bad, want.ovf,
                                got.day, got.month, got.year, got.bad, got.ovf);
                        end
                    end
                end
            end
            if (start && !busy) begin
                if (pend_known) begin
                    expected_dates.push_back(pend_res);
                end else begin
                    expected_dates.push_back(predict_date(i_day_count, i_day, i_month, i_year));
                end
            end
            if (o_done || (start && !busy)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, random items, drain.
    initial begin
        logic [dad_pkg::COUNT_BITS-1:0] cnt;
        logic [dad_pkg::DAY_W-1:0]      d;
        logic [dad_pkg::MONTH_W-1:0]    m;
        logic [dad_pkg::YEAR_W-1:0]     y;
        int unsigned                    len, sel;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_day_count  = '0;
        i_day        = '0;
        i_month      = '0;
        i_year       = '0;
        pend_known   = 1'b0;
        pend_res     = NO_RES;
        mismatch_cnt = 0;
        idle_cycles  = 0;

        // Plain steps, month and year rollover, leap days and century rules.
        add_row(0,     1,  1,  2000,  1, res_of(1, 1, 2000, 0, 0));
        add_row(1,     31, 12, 1999,  1, res_of(1, 1, 2000, 0, 0));
        add_row(1,     28, 2,  2000,  1, res_of(29, 2, 2000, 0, 0));
        add_row(1,     28, 2,  1900,  1, res_of(1, 3, 1900, 0, 0));
        add_row(1,     28, 2,  2100,  1, res_of(1, 3, 2100, 0, 0));
        add_row(1,     29, 2,  0,     1, res_of(1, 3, 0, 0, 0));
        // Invalid dates are flagged and echoed.
        add_row(0,     29, 2,  1900,  1, res_of(29, 2, 1900, 1, 0));
        add_row(5,     0,  1,  5,     1, res_of(0, 1, 5, 1, 0));
        add_row(5,     1,  0,  5,     1, res_of(1, 0, 5, 1, 0));
        add_row(65535, 31, 15, 16383, 1, res_of(31, 15, 16383, 1, 0));
        add_row(1,     31, 4,  2024,  1, res_of(31, 4, 2024, 1, 0));
        add_row(1,     31, 13, 2024,  1, res_of(31, 13, 2024, 1, 0));
        add_row(1,     30, 2,  2000,  1, res_of(30, 2, 2000, 1, 0));
        // Year overflow and the very last date.
        add_row(1,     31, 12, 16383, 1, res_of(31, 12, 16383, 0, 1));
        add_row(0,     31, 12, 16383, 1, res_of(31, 12, 16383, 0, 0));
        // Full-width counts and longer spans.
        add_row(65535, 1,  1,  0,     0, NO_RES);
        add_row(65535, 1,  1,  16300, 0, NO_RES);
        add_row(65535, 1,  1,  16203, 0, NO_RES);
        add_row(65535, 31, 12, 16204, 0, NO_RES);
        add_row(365,   29, 2,  2000,  0, NO_RES);
        add_row(28,    31, 1,  2023,  0, NO_RES);
        add_row(306,   1,  3,  1999,  0, NO_RES);
        add_row(59,    1,  1,  2000,  0, NO_RES);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_item(dir_rows[k].count, dir_rows[k].day, dir_rows[k].month,
                      dir_rows[k].year, dir_rows[k].known, dir_rows[k].res);
        end

        // Random items: mostly valid dates, some malformed ones.
        for (int n = 0; n < N_RANDOM; n++) begin
            sel = $urandom_range(0, 9);
            if (sel < 2) begin
                y = dad_pkg::YEAR_W'($urandom_range(16150, 16383));
            end else if (sel == 2) begin
                y = dad_pkg::YEAR_W'($urandom_range(0, 163) * 100);
            end else if (sel == 3) begin
                y = dad_pkg::YEAR_W'($urandom_range(0, 50));
            end else begin
                y = dad_pkg::YEAR_W'($urandom_range(0, 16383));
            end
            m   = dad_pkg::MONTH_W'($urandom_range(1, 12));
            len = month_days(m, y);
            d   = ($urandom_range(0, 3) == 0) ? dad_pkg::DAY_W'(len) :
                                                dad_pkg::DAY_W'($urandom_range(1, len));
            sel = $urandom_range(0, 3);
            if (sel == 0) begin
                cnt = dad_pkg::COUNT_BITS'($urandom_range(0, 40));
            end else if (sel == 1) begin
                cnt = dad_pkg::COUNT_BITS'($urandom_range(0, 800));
            end else if (sel == 2) begin
                cnt = dad_pkg::COUNT_BITS'($urandom);
            end else begin
                cnt = ~dad_pkg::COUNT_BITS'($urandom_range(0, 600));
            end
            // Malformed dates: bad month codes, day zero, day past month end.
            if ($urandom_range(0, 99) < 10) begin
                sel = $urandom_range(0, 2);
                if (sel == 0) begin
                    m = ($urandom_range(0, 1) == 0) ? '0 :
                                                      dad_pkg::MONTH_W'($urandom_range(13, 15));
                    d = dad_pkg::DAY_W'($urandom_range(0, 31));
                end else if (sel == 1 || len == 31) begin
                    d = '0;
                end else begin
                    d = dad_pkg::DAY_W'($urandom_range(len + 1, 31));
                end
            end
            send_item(cnt, d, m, y, 1'b0, NO_RES);
        end
        @(negedge i_clk);
        start <= 1'b0;

        // Drain the outstanding results; the watchdog bounds this wait.
        while (expected_dates.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
